[hw/rtl/mktm_pkg.sv]
package mktm_pkg;

	localparam int PITCH_CLASSES = 12;
	localparam int PATTERN_W     = 12;
	localparam int KEYCNT_W      = 4;
	localparam int ROOT_W        = 4;
	localparam int SCORE_W       = 21;
	localparam int CFG_INDEX_W   = 1;
	localparam int CFG_DATA_W    = 12;
	localparam int OUT_TDATA_W   = 32;

	localparam logic [PATTERN_W-1:0] PATTERN_RESET = 12'd2741;
	localparam logic [KEYCNT_W-1:0]  KEYCNT_RESET  = 4'd12;
	localparam logic [KEYCNT_W-1:0]  KEYCNT_MAX    = 4'd12;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_SCALE_PATTERN = 1'b0,
		REG_KEY_COUNT     = 1'b1
	} cfg_reg_t;

	typedef logic [ROOT_W-1:0] root_t;

	typedef struct packed {
		logic [PATTERN_W-1:0]     pattern;
		logic [PITCH_CLASSES-1:0] root_en;
	} mktm_cfg_t;

endpackage

[hw/rtl/mktm_pipe.sv]
module mktm_pipe #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic                                                clk,
	input  logic                                                arst_n,
	input  mktm_pkg::mktm_cfg_t                                 cfg,
	input  logic                                                in_valid,
	output logic                                                in_ready,
	input  logic [mktm_pkg::PITCH_CLASSES-1:0][COUNT_WIDTH-1:0] counts,
	output logic                                                out_valid,
	input  logic                                                out_ready,
	output mktm_pkg::root_t                                     out_root,
	output logic [mktm_pkg::SCORE_W-1:0]                        out_score
);

	localparam int NPC    = mktm_pkg::PITCH_CLASSES;
	localparam int NGRP   = 3;
	localparam int GRP_SZ = NPC / NGRP;
	localparam int NPAIR  = NPC / 2;
	localparam int NQUAD  = NPAIR / 2;
	localparam int PW     = COUNT_WIDTH + 2;
	localparam int AW     = COUNT_WIDTH + 4;
	localparam int SW     = COUNT_WIDTH + 6;

	logic en;
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;

	logic [NPC-1:0][NGRP-1:0][PW-1:0] part_s1;
	logic [NGRP-1:0][PW-1:0]          totp_s1;
	logic [NPC-1:0][AW-1:0]           a_s2;
	logic [AW-1:0]                    tot_s2;
	logic [NPAIR-1:0][AW-1:0]         a_s3;
	mktm_pkg::root_t [NPAIR-1:0]      root_s3;
	logic [NPAIR-1:0]                 en_s3;
	logic [AW-1:0]                    tot_s3;
	logic [NQUAD-1:0][AW-1:0]         a_s4;
	mktm_pkg::root_t [NQUAD-1:0]      root_s4;
	logic [NQUAD-1:0]                 en_s4;
	logic [AW-1:0]                    tot_s4;
	logic [AW-1:0]                    a_s5;
	mktm_pkg::root_t                  root_s5;
	logic [AW-1:0]                    tot_s5;
	mktm_pkg::root_t                  root_s6;
	logic [mktm_pkg::SCORE_W-1:0]     score_s6;

	logic [NPC-1:0][NGRP-1:0][PW-1:0] part_d;
	logic [NGRP-1:0][PW-1:0]          totp_d;
	logic [NPC-1:0][AW-1:0]           a_d;
	logic [AW-1:0]                    tot_d;
	logic [NPAIR-1:0][AW-1:0]         pa_d;
	mktm_pkg::root_t [NPAIR-1:0]      proot_d;
	logic [NQUAD-1:0][AW-1:0]         qa_d;
	mktm_pkg::root_t [NQUAD-1:0]      qroot_d;
	logic [AW-1:0]                    ba_d;
	mktm_pkg::root_t                  broot_d;
	logic [SW-1:0]                    diff_d;

	assign en       = !valid_s6 || out_ready;
	assign in_ready = en;

	// Stage 1: per root, three partial sums of the counts its rotated pattern allows, and three partial totals.
	always_comb begin
		int idx;
		int pc;
		for (int r = 0; r < NPC; r++) begin
			for (int g = 0; g < NGRP; g++) begin
				part_d[r][g] = '0;
				for (int k = 0; k < GRP_SZ; k++) begin
					pc  = g * GRP_SZ + k;
					idx = (pc >= r) ? (pc - r) : (pc + NPC - r);
					if (cfg.pattern[idx]) begin
						part_d[r][g] = part_d[r][g] + PW'(counts[pc]);
					end
				end
			end
		end
		for (int g = 0; g < NGRP; g++) begin
			totp_d[g] = '0;
			for (int k = 0; k < GRP_SZ; k++) begin
				totp_d[g] = totp_d[g] + PW'(counts[g * GRP_SZ + k]);
			end
		end
	end

	// Stage 2: allowed sum per root and the total of all counts.
	always_comb begin
		for (int r = 0; r < NPC; r++) begin
			a_d[r] = AW'(part_s1[r][0]) + AW'(part_s1[r][1]) + AW'(part_s1[r][2]);
		end
		tot_d = AW'(totp_s1[0]) + AW'(totp_s1[1]) + AW'(totp_s1[2]);
	end

	// The score 2*A - T rises with A, so the roots are ranked on A alone.
	// A later root replaces an earlier one only when enabled and strictly larger.
	always_comb begin
		for (int p = 0; p < NPAIR; p++) begin
			if (cfg.root_en[2 * p + 1] && (a_s2[2 * p + 1] > a_s2[2 * p])) begin
				pa_d[p]    = a_s2[2 * p + 1];
				proot_d[p] = mktm_pkg::ROOT_W'(2 * p + 1);
			end else begin
				pa_d[p]    = a_s2[2 * p];
				proot_d[p] = mktm_pkg::ROOT_W'(2 * p);
			end
		end
		for (int q = 0; q < NQUAD; q++) begin
			if (en_s3[2 * q + 1] && (a_s3[2 * q + 1] > a_s3[2 * q])) begin
				qa_d[q]    = a_s3[2 * q + 1];
				qroot_d[q] = root_s3[2 * q + 1];
			end else begin
				qa_d[q]    = a_s3[2 * q];
				qroot_d[q] = root_s3[2 * q];
			end
		end
		ba_d    = a_s4[0];
		broot_d = root_s4[0];
		for (int q = 1; q < NQUAD; q++) begin
			if (en_s4[q] && (a_s4[q] > ba_d)) begin
				ba_d    = a_s4[q];
				broot_d = root_s4[q];
			end
		end
		diff_d = (SW'(a_s5) << 1) - SW'(tot_s5);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			part_s1  <= part_d;
			totp_s1  <= totp_d;
			a_s2     <= a_d;
			tot_s2   <= tot_d;
			a_s3     <= pa_d;
			root_s3  <= proot_d;
			tot_s3   <= tot_s2;
			for (int p = 0; p < NPAIR; p++) begin
				en_s3[p] <= cfg.root_en[2 * p];
			end
			a_s4     <= qa_d;
			root_s4  <= qroot_d;
			tot_s4   <= tot_s3;
			for (int q = 0; q < NQUAD; q++) begin
				en_s4[q] <= en_s3[2 * q];
			end
			a_s5     <= ba_d;
			root_s5  <= broot_d;
			tot_s5   <= tot_s4;
			root_s6  <= root_s5;
			score_s6 <= mktm_pkg::SCORE_W'($signed(diff_d));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
		end
	end

	assign out_valid = valid_s6;
	assign out_root  = root_s6;
	assign out_score = score_s6;

endmodule

[hw/rtl/musical_key_template_match.sv]
// Channel | Direction | Contents
// s_*     | in        | twelve pitch-class counts, one item per histogram
// m_*     | out       | best root and its score, one item per input item
// cfg_*   | in        | register writes: scale pattern, key count
//
// An item enters every cycle unless a result waits at m_tdata while m_tready is low.
// The six register stages are partial sums, root sums, two compare levels, a final
// three-way compare and the score subtract. The whole pipeline holds while a result
// waits at m_tdata, and s_tready follows from m_tready in the same cycle.
// Reset clears the valid bits and loads the major scale with twelve roots.
module musical_key_template_match #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    s_tvalid,
	output logic                                    s_tready,
	// count_pc0 .. count_pc11, COUNT_WIDTH bits each, then zero fill.
	input  logic [((mktm_pkg::PITCH_CLASSES * COUNT_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
	output logic                                    m_tvalid,
	input  logic                                    m_tready,
	// best_root [3:0], key_score [24:4], zero fill [31:25].
	output logic [mktm_pkg::OUT_TDATA_W-1:0]        m_tdata,
	input  logic                                    cfg_valid,
	output logic                                    cfg_ready,
	input  logic [mktm_pkg::CFG_INDEX_W-1:0]        cfg_index,
	input  logic [mktm_pkg::CFG_DATA_W-1:0]         cfg_data
);

	localparam int NPC = mktm_pkg::PITCH_CLASSES;

	logic [mktm_pkg::PATTERN_W-1:0] pattern_q;
	logic [mktm_pkg::KEYCNT_W-1:0]  key_count_q;
	logic [mktm_pkg::KEYCNT_W-1:0]  nkeys;
	mktm_pkg::mktm_cfg_t            cfg;
	logic [NPC-1:0][COUNT_WIDTH-1:0] counts;
	mktm_pkg::root_t                best_root;
	logic [mktm_pkg::SCORE_W-1:0]   key_score;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q   <= mktm_pkg::PATTERN_RESET;
			key_count_q <= mktm_pkg::KEYCNT_RESET;
		end else if (cfg_valid) begin
			case (mktm_pkg::cfg_reg_t'(cfg_index))
				mktm_pkg::REG_SCALE_PATTERN: pattern_q <= cfg_data;
				mktm_pkg::REG_KEY_COUNT: key_count_q <= cfg_data[mktm_pkg::KEYCNT_W-1:0];
				default: ;
			endcase
		end
	end

	// A key count of zero still tries root zero; counts above twelve saturate.
	always_comb begin
		if (key_count_q == '0) begin
			nkeys = mktm_pkg::KEYCNT_W'(1);
		end else if (key_count_q > mktm_pkg::KEYCNT_MAX) begin
			nkeys = mktm_pkg::KEYCNT_MAX;
		end else begin
			nkeys = key_count_q;
		end
		cfg.pattern = pattern_q;
		for (int r = 0; r < NPC; r++) begin
			cfg.root_en[r] = (mktm_pkg::KEYCNT_W'(r) < nkeys);
		end
	end

	for (genvar pc = 0; pc < NPC; pc++) begin : g_unpack
		assign counts[pc] = s_tdata[pc * COUNT_WIDTH +: COUNT_WIDTH];
	end

	mktm_pipe #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_pipe (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.counts   (counts),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_root (best_root),
		.out_score(key_score)
	);

	assign m_tdata = {
		(mktm_pkg::OUT_TDATA_W - mktm_pkg::ROOT_W - mktm_pkg::SCORE_W)'(0),
		key_score,
		best_root
	};

`ifndef SYNTHESIS
	a_root_enabled: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[mktm_pkg::ROOT_W-1:0] < nkeys))
		else $error("result root lies outside the configured key count");

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |-> !s_tready)
		else $error("input taken while a result is stalled");

	a_stall_holds_result: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready && !cfg_valid) |=> (m_tvalid && $stable(m_tdata)))
		else $error("stalled result changed");
`endif

endmodule
